// ----- hw/rtl/tss_pkg.sv -----
`timescale 1ns / 1ps

package tss_pkg;

    localparam int MAX_LEVEL = 29;
    localparam int LVL_W     = 5;

    typedef logic [MAX_LEVEL-1:0] coord_t;
    typedef logic [LVL_W-1:0]     level_t;

    typedef struct packed {
        coord_t      x;
        coord_t      y;
        level_t      el;
        logic        et;
        level_t      tl;
        logic [2:0]  step;
        logic        ok;
        coord_t      oh_tl;
        coord_t      srch;
        logic        typ_tl;
        logic [1:0]  cube_tl;
        logic        typ_tlm1;
        logic        up;
        logic        dn;
        logic [1:0]  nli;
        coord_t      cand;
        coord_t      oh_top;
        coord_t      between;
        logic [1:0]  cube_top;
        logic        root;
    } pipe_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        level_t level;
        logic   typ;
        logic   nn;
    } result_t;

    // child cube id from parent type and local index
    function automatic logic [1:0] cid_of(input logic p, input logic [1:0] li);
        logic [1:0] c;
        case (li)
            2'd0:    c = 2'd0;
            2'd3:    c = 2'd3;
            default: c = p ? 2'd2 : 2'd1;
        endcase
        return c;
    endfunction

    // child type from parent type and local index
    function automatic logic type_of(input logic p, input logic [1:0] li);
        logic t;
        case (li)
            2'd1:    t = 1'b0;
            2'd2:    t = 1'b1;
            default: t = p;
        endcase
        return t;
    endfunction

    // local index from cube id and own type
    function automatic logic [1:0] local_of(input logic [1:0] c, input logic t);
        logic [1:0] l;
        case (c)
            2'd0:    l = 2'd0;
            2'd3:    l = 2'd3;
            default: l = t ? 2'd2 : 2'd1;
        endcase
        return l;
    endfunction

endpackage

// ----- hw/rtl/tss_rebuild.sv -----
`timescale 1ns / 1ps

module tss_rebuild import tss_pkg::*; (
    input  pipe_t   p,
    output result_t r
);

    logic       p0;
    logic       p1;
    logic [1:0] li_top;
    logic [1:0] c_top;
    logic [1:0] c_tl;
    coord_t     oh_top;
    coord_t     btw;
    coord_t     mid_val;

    always_comb begin
        p0      = (p.cube_top[0] ^ p.cube_top[1]) ? p.cube_top[1] : p.typ_tlm1;
        li_top  = p.up ? local_of(p.cube_top, p.typ_tlm1) + 2'd1
                       : local_of(p.cube_top, p.typ_tlm1) - 2'd1;
        c_top   = cid_of(p0, li_top);
        p1      = (p.up || p.dn) ? type_of(p0, li_top) : p.typ_tlm1;
        c_tl    = cid_of(p1, p.nli);
        oh_top  = (p.up || p.dn) ? p.oh_top : '0;
        btw     = (p.up || p.dn) ? p.between : '0;
        mid_val = p.dn ? p.between : '0;

        r.x     = p.x;
        r.y     = p.y;
        r.level = p.el;
        r.typ   = p.et;
        r.nn    = !p.ok || p.root;
        if (p.ok && !p.root && (p.step != 3'd0)) begin
            r.x = (p.x & ~(oh_top | btw | p.oh_tl)) | mid_val
                | (c_top[0] ? oh_top : '0) | (c_tl[0] ? p.oh_tl : '0);
            r.y = (p.y & ~(oh_top | btw | p.oh_tl)) | mid_val
                | (c_top[1] ? oh_top : '0) | (c_tl[1] ? p.oh_tl : '0);
            r.level = p.tl;
            r.typ   = type_of(p1, p.nli);
        end
    end

endmodule

// ----- hw/rtl/triangle_sfc_successor.sv -----
// a request passes through p1_reg, p2_reg, p3_reg, p4_reg and res_reg before its result is valid
// throughput: one request per cycle, stalls only while the result is held
// the pipeline is four search stages plus the output register, all moving together
// reset: synchronous active-low aresetn clears all stage valid bits
`timescale 1ns / 1ps

module triangle_sfc_successor import tss_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  coord_t     s_elem_x,
    input  coord_t     s_elem_y,
    input  level_t     s_elem_level,
    input  logic       s_elem_type,
    input  level_t     s_target_level,
    input  logic signed [2:0] s_step,
    output logic       m_valid,
    input  logic       m_ready,
    output coord_t     m_out_x,
    output coord_t     m_out_y,
    output level_t     m_out_level,
    output logic       m_out_type,
    output logic       m_no_neighbor
);

    logic    en;
    logic    v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    pipe_t   p1_reg, p2_reg, p3_reg, p4_reg;
    pipe_t   p1_next, p2_next, p3_next, p4_next;
    result_t res_reg, res_next;
    coord_t  smear;
    coord_t  hi;
    logic [1:0] loc;
    logic [3:0] n;
    coord_t  above;

    assign en      = !vo_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        p1_next       = '0;
        p1_next.x     = s_elem_x;
        p1_next.y     = s_elem_y;
        p1_next.el    = s_elem_level;
        p1_next.et    = s_elem_type;
        p1_next.tl    = s_target_level;
        p1_next.step  = s_step;
        p1_next.ok    = (s_target_level != '0) && (s_target_level <= s_elem_level)
                      && (s_elem_level <= level_t'(MAX_LEVEL));
        p1_next.oh_tl = coord_t'(1) << (level_t'(MAX_LEVEL) - s_target_level);
        p1_next.srch  = (s_elem_x ^ s_elem_y) & (p1_next.oh_tl - coord_t'(1))
                      & ~((coord_t'(1) << (level_t'(MAX_LEVEL) - s_elem_level))
                      - coord_t'(1));
    end

    // nearest type-setting cube above the target level
    always_comb begin
        p2_next = p1_reg;
        smear   = p1_reg.srch;
        for (int k = 1; k < MAX_LEVEL; k = k * 2) begin
            smear = smear | (smear >> k);
        end
        hi = p1_reg.srch & ~(smear >> 1);
        p2_next.typ_tl  = (p1_reg.srch != '0) ? |(hi & p1_reg.y) : p1_reg.et;
        p2_next.cube_tl = {|(p1_reg.y & p1_reg.oh_tl), |(p1_reg.x & p1_reg.oh_tl)};
    end

    always_comb begin
        p3_next = p2_reg;
        p3_next.typ_tlm1 = (p2_reg.cube_tl[0] ^ p2_reg.cube_tl[1]) ? p2_reg.cube_tl[1]
                                                                 : p2_reg.typ_tl;
        loc  = local_of(p2_reg.cube_tl, p2_reg.typ_tl);
        n    = {2'b00, loc} + {p2_reg.step[2], p2_reg.step};
        p3_next.up  = !n[3] && n[2];
        p3_next.dn  = n[3];
        p3_next.nli = n[1:0];
        above = ~((p2_reg.oh_tl << 1) - coord_t'(1));
        p3_next.cand = (n[3] ? (p2_reg.x | p2_reg.y) : ~(p2_reg.x & p2_reg.y)) & above;
    end

    always_comb begin
        p4_next = p3_reg;
        p4_next.oh_top   = p3_reg.cand & (~p3_reg.cand + coord_t'(1));
        p4_next.root     = (p3_reg.up || p3_reg.dn) && (p3_reg.cand == '0);
        p4_next.between  = (p4_next.oh_top - coord_t'(1))
                         & ~((p3_reg.oh_tl << 1) - coord_t'(1));
        p4_next.cube_top = {|(p3_reg.y & p4_next.oh_top), |(p3_reg.x & p4_next.oh_top)};
    end

    tss_rebuild u_rebuild (
        .p (p4_reg),
        .r (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            res_reg <= res_next;
        end
    end

    assign m_valid       = vo_reg;
    assign m_out_x       = res_reg.x;
    assign m_out_y       = res_reg.y;
    assign m_out_level   = res_reg.level;
    assign m_out_type    = res_reg.typ;
    assign m_no_neighbor = res_reg.nn;

`ifndef NO_ASSERTIONS
    a_ready: assert property (@(posedge aclk) s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stall");
    a_top_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> $onehot0(p4_reg.oh_top))
        else $error("carry stop level not one-hot");
    a_root_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && p4_reg.root) |-> (p4_reg.up || p4_reg.dn))
        else $error("root pass without carry");
    a_carry_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !(p3_reg.up && p3_reg.dn))
        else $error("carry both ways");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !en) |=> v4_reg)
        else $error("stage lost during stall");
`endif

endmodule
